### rtl/mi3_pkg.sv
// Shared types and pipeline constants for the 3x3 fixed-point matrix inverse.
// No dependencies; every other file in rtl imports this package.
package mi3_pkg;

    localparam int ORDER      = 3;
    localparam int NELEM      = ORDER * ORDER;
    localparam int ELEM_W     = 32;
    localparam int COF_W      = 65;
    localparam int DET_W      = 97;
    localparam int QBITS      = 33;
    localparam int FRONT_LAT  = 5;
    localparam int LANE_LAT   = QBITS + 3;
    localparam int TOTAL_LAT  = FRONT_LAT + LANE_LAT;

    typedef logic [ELEM_W-1:0]        elem_t;
    typedef logic [NELEM-1:0][ELEM_W-1:0] mat_t;
    typedef logic signed [COF_W-1:0]  cof_t;
    typedef logic signed [DET_W-1:0]  det_t;

    typedef struct packed {
        mat_t res;
        logic singular;
        logic clipped;
    } out_t;

endpackage

### rtl/mi3_front.sv
// Cofactor and determinant pipeline: products, cofactors, split multiplies for
// the first-row expansion, and the determinant sum. Depends on mi3_pkg.
module mi3_front (
    input  logic                       aclk,
    input  logic                       ce,
    input  mi3_pkg::mat_t              mat,
    output mi3_pkg::cof_t              cof [mi3_pkg::NELEM],
    output mi3_pkg::det_t              det
);
    import mi3_pkg::*;

    logic signed [63:0] pa_reg [NELEM];
    logic signed [63:0] pb_reg [NELEM];
    elem_t row_b_reg [ORDER];
    elem_t row_a_reg [ORDER];
    cof_t  cof_b_reg [NELEM];
    cof_t  cof_c_reg [NELEM];
    cof_t  cof_d_reg [NELEM];
    cof_t  cof_e_reg [NELEM];
    logic signed [64:0] plo_reg [ORDER];
    logic signed [64:0] phi_reg [ORDER];
    det_t  term_reg [ORDER];
    det_t  det_reg;

    // Stage one: the two products of every 2x2 minor.
    for (genvar r = 0; r < ORDER; r++) begin : g_row
        for (genvar c = 0; c < ORDER; c++) begin : g_col
            localparam int R1 = (r + 1) % ORDER;
            localparam int R2 = (r + 2) % ORDER;
            localparam int C1 = (c + 1) % ORDER;
            localparam int C2 = (c + 2) % ORDER;
            always_ff @(posedge aclk) begin
                if (ce) begin
                    pa_reg[r*ORDER+c] <= $signed(mat[R1*ORDER+C1]) * $signed(mat[R2*ORDER+C2]);
                    pb_reg[r*ORDER+c] <= $signed(mat[R1*ORDER+C2]) * $signed(mat[R2*ORDER+C1]);
                end
            end
        end
    end

    // Stage two: cofactors; stages three to five carry them alongside.
    for (genvar i = 0; i < NELEM; i++) begin : g_cof
        always_ff @(posedge aclk) begin
            if (ce) begin
                cof_b_reg[i] <= {pa_reg[i][63], pa_reg[i]} - {pb_reg[i][63], pb_reg[i]};
                cof_c_reg[i] <= cof_b_reg[i];
                cof_d_reg[i] <= cof_c_reg[i];
                cof_e_reg[i] <= cof_d_reg[i];
            end
        end
        assign cof[i] = cof_e_reg[i];
    end

    // First-row elements follow the products, then each row-0 term is
    // formed from two 32x33 partial products.
    for (genvar c = 0; c < ORDER; c++) begin : g_det
        always_ff @(posedge aclk) begin
            if (ce) begin
                row_a_reg[c] <= mat[c];
                row_b_reg[c] <= row_a_reg[c];
                plo_reg[c]   <= $signed(row_b_reg[c]) * $signed({1'b0, cof_b_reg[c][31:0]});
                phi_reg[c]   <= $signed(row_b_reg[c]) * $signed(cof_b_reg[c][64:32]);
                term_reg[c]  <= $signed({phi_reg[c], 32'd0})
                              + $signed({{(DET_W-65){plo_reg[c][64]}}, plo_reg[c]});
            end
        end
    end

    // Determinant sum.
    always_ff @(posedge aclk) begin
        if (ce) begin
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
        end
    end

    assign det = det_reg;

endmodule

### rtl/mi3_lane.sv
// One division lane: scales a cofactor by the reciprocal of the determinant
// with a restoring divider, one quotient bit per stage, then rounds and
// saturates. Depends on mi3_pkg.
module mi3_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic           aclk,
    input  logic           ce,
    input  mi3_pkg::cof_t  cof,
    input  mi3_pkg::det_t  det,
    output mi3_pkg::elem_t res,
    output logic           clip
);
    import mi3_pkg::*;

    localparam int WW = 2 * FRAC_BITS + 132;

    logic [COF_W-1:0] cmag;
    logic [DET_W-1:0] dmag;
    logic [WW-1:0]    num_reg;
    logic [WW-1:0]    den1_reg;
    logic             neg1_reg;

    logic [WW-1:0]    rem_reg [QBITS];
    logic [WW-1:0]    den_reg [QBITS];
    logic [QBITS-1:0] q_reg   [QBITS+1];
    logic             neg_reg [QBITS+1];
    logic             ovf_reg [QBITS+1];

    logic [QBITS-1:0] lim;
    logic [QBITS-1:0] mag;
    logic             sat;
    elem_t            res_reg;
    logic             clip_reg;

    // Magnitudes and the rounded numerator, den = 2|D|.
    assign cmag = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
    assign dmag = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);

    always_ff @(posedge aclk) begin
        if (ce) begin
            num_reg  <= (WW'(cmag) << (2 * FRAC_BITS + 1)) + WW'(dmag);
            den1_reg <= WW'(dmag) << 1;
            neg1_reg <= cof[COF_W-1] ^ det[DET_W-1];
        end
    end

    // A quotient of 2^33 or more always saturates.
    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0] <= num_reg;
            den_reg[0] <= den1_reg;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg1_reg;
            ovf_reg[0] <= num_reg >= (den1_reg << QBITS);
        end
    end

    // Restoring division, most significant quotient bit first.
    for (genvar j = 0; j < QBITS; j++) begin : g_div
        localparam int K = QBITS - 1 - j;
        logic [WW-1:0] trial;
        logic          take;
        assign trial = den_reg[j] << K;
        assign take  = rem_reg[j] >= trial;
        always_ff @(posedge aclk) begin
            if (ce) begin
                q_reg[j+1]   <= {q_reg[j][QBITS-2:0], take};
                neg_reg[j+1] <= neg_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
        // The partial remainder and divisor are only needed by a later stage.
        if (j < QBITS - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[j+1] <= take ? (rem_reg[j] - trial) : rem_reg[j];
                    den_reg[j+1] <= den_reg[j];
                end
            end
        end
    end

    // Saturate to the signed 32-bit range and apply the sign.
    assign lim = neg_reg[QBITS] ? QBITS'(33'h0_8000_0000) : QBITS'(33'h0_7FFF_FFFF);
    assign sat = ovf_reg[QBITS] || (q_reg[QBITS] > lim);
    assign mag = sat ? lim : q_reg[QBITS];

    always_ff @(posedge aclk) begin
        if (ce) begin
            res_reg  <= neg_reg[QBITS] ? ELEM_W'(-mag) : ELEM_W'(mag);
            clip_reg <= sat;
        end
    end

    assign res  = res_reg;
    assign clip = clip_reg;

endmodule

### rtl/mi3_merge.sv
// Merge stage: gathers the nine lane results, ORs the clip flags, and echoes
// the input matrix when the determinant is zero. Depends on mi3_pkg.
module mi3_merge (
    input  mi3_pkg::elem_t lane_res  [mi3_pkg::NELEM],
    input  logic           lane_clip [mi3_pkg::NELEM],
    input  mi3_pkg::mat_t  mat,
    input  logic           det_zero,
    output mi3_pkg::out_t  result
);
    import mi3_pkg::*;

    logic any_clip;

    // Clip summary over all lanes.
    always_comb begin
        any_clip = 1'b0;
        for (int i = 0; i < NELEM; i++) begin
            any_clip = any_clip | lane_clip[i];
        end
    end

    // Select the echoed matrix or the computed inverse.
    always_comb begin
        for (int i = 0; i < NELEM; i++) begin
            result.res[i] = det_zero ? mat[i] : lane_res[i];
        end
        result.singular = det_zero;
        result.clipped  = any_clip & ~det_zero;
    end

endmodule

### rtl/matrix_inverse_3x3_unit.sv
// 3x3 fixed-point matrix inverse by the adjugate, nine parallel divider lanes.
// Throughput: one matrix per cycle while the output buffer has room, set by the
// fully pipelined 33-stage restoring dividers; a two-entry output buffer
// decouples the result side.
// Reset (aresetn, synchronous, active low) clears the pipeline valid bits and
// the output buffer; data registers are not reset.
module matrix_inverse_3x3_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_m00,
    input  logic signed [31:0]   s_m01,
    input  logic signed [31:0]   s_m02,
    input  logic signed [31:0]   s_m10,
    input  logic signed [31:0]   s_m11,
    input  logic signed [31:0]   s_m12,
    input  logic signed [31:0]   s_m20,
    input  logic signed [31:0]   s_m21,
    input  logic signed [31:0]   s_m22,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_r00,
    output logic signed [31:0]   m_r01,
    output logic signed [31:0]   m_r02,
    output logic signed [31:0]   m_r10,
    output logic signed [31:0]   m_r11,
    output logic signed [31:0]   m_r12,
    output logic signed [31:0]   m_r20,
    output logic signed [31:0]   m_r21,
    output logic signed [31:0]   m_r22,
    output logic                 m_singular,
    output logic                 m_clipped
);
    import mi3_pkg::*;

    mat_t  in_mat;
    cof_t  cof [NELEM];
    det_t  det;
    elem_t lane_res  [NELEM];
    logic  lane_clip [NELEM];
    out_t  merged;

    logic [TOTAL_LAT-1:0] vld_reg;
    logic [TOTAL_LAT-1:0] vld_next;
    mat_t                 mat_reg  [TOTAL_LAT];
    logic                 zero_reg [LANE_LAT];

    out_t       buf_reg [2];
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       ce;
    logic       push;
    logic       pop;
    logic       push_head;

    assign in_mat = {s_m22, s_m21, s_m20, s_m12, s_m11, s_m10, s_m02, s_m01, s_m00};

    // The pipeline advances whenever the output buffer has room.
    assign ce      = (cnt_reg != 2'd2);
    assign s_ready = ce;
    assign push    = ce && vld_reg[TOTAL_LAT-1];
    assign pop     = m_valid && m_ready;

    mi3_front u_front (
        .aclk (aclk),
        .ce   (ce),
        .mat  (in_mat),
        .cof  (cof),
        .det  (det)
    );

    // Lane (r,c) divides the transposed cofactor (c,r).
    for (genvar r = 0; r < ORDER; r++) begin : g_lr
        for (genvar c = 0; c < ORDER; c++) begin : g_lc
            mi3_lane #(
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .aclk (aclk),
                .ce   (ce),
                .cof  (cof[c*ORDER+r]),
                .det  (det),
                .res  (lane_res[r*ORDER+c]),
                .clip (lane_clip[r*ORDER+c])
            );
        end
    end

    mi3_merge u_merge (
        .lane_res  (lane_res),
        .lane_clip (lane_clip),
        .mat       (mat_reg[TOTAL_LAT-1]),
        .det_zero  (zero_reg[LANE_LAT-1]),
        .result    (merged)
    );

    // Valid bits travel with each beat.
    assign vld_next = {vld_reg[TOTAL_LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= vld_next;
        end
    end

    // Input matrix and zero-determinant flag delayed to the merge stage.
    always_ff @(posedge aclk) begin
        if (ce) begin
            mat_reg[0]  <= in_mat;
            zero_reg[0] <= (det == '0);
            for (int i = 1; i < TOTAL_LAT; i++) begin
                mat_reg[i] <= mat_reg[i-1];
            end
            for (int i = 1; i < LANE_LAT; i++) begin
                zero_reg[i] <= zero_reg[i-1];
            end
        end
    end

    // Two-entry output buffer; entry zero is the head.
    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // A new beat lands at the head when the buffer is, or is becoming, empty.
    assign push_head = push && ((cnt_reg == 2'd0) || (pop && cnt_reg == 2'd1));

    always_ff @(posedge aclk) begin
        if (push_head) begin
            buf_reg[0] <= merged;
        end else if (pop) begin
            buf_reg[0] <= buf_reg[1];
        end
        if (push && !push_head) begin
            buf_reg[1] <= merged;
        end
    end

    assign m_valid    = (cnt_reg != 2'd0);
    assign m_r00      = buf_reg[0].res[0];
    assign m_r01      = buf_reg[0].res[1];
    assign m_r02      = buf_reg[0].res[2];
    assign m_r10      = buf_reg[0].res[3];
    assign m_r11      = buf_reg[0].res[4];
    assign m_r12      = buf_reg[0].res[5];
    assign m_r20      = buf_reg[0].res[6];
    assign m_r21      = buf_reg[0].res[7];
    assign m_r22      = buf_reg[0].res[8];
    assign m_singular = buf_reg[0].singular;
    assign m_clipped  = buf_reg[0].clipped;

endmodule

### test/matrix_inverse_3x3_unit_test.sv
// Self-checking bench for the 3x3 fixed-point matrix inverse: directed table plus random matrices.
// Depends on mi3_pkg and matrix_inverse_3x3_unit; each result is checked against table or model.
`timescale 1ns / 100ps

module matrix_inverse_3x3_unit_test;
    import mi3_pkg::*;

    localparam int FRAC       = 16;
    localparam int RAND_ITEMS = 1040;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_LEN   = 300;

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    elem_t s_m00 = '0, s_m01 = '0, s_m02 = '0;
    elem_t s_m10 = '0, s_m11 = '0, s_m12 = '0;
    elem_t s_m20 = '0, s_m21 = '0, s_m22 = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    elem_t m_r00, m_r01, m_r02, m_r10, m_r11, m_r12, m_r20, m_r21, m_r22;
    logic  m_singular, m_clipped;

    matrix_inverse_3x3_unit #(.FRAC_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_m00(s_m00), .s_m01(s_m01), .s_m02(s_m02),
        .s_m10(s_m10), .s_m11(s_m11), .s_m12(s_m12),
        .s_m20(s_m20), .s_m21(s_m21), .s_m22(s_m22),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_r00(m_r00), .m_r01(m_r01), .m_r02(m_r02),
        .m_r10(m_r10), .m_r11(m_r11), .m_r12(m_r12),
        .m_r20(m_r20), .m_r21(m_r21), .m_r22(m_r22),
        .m_singular(m_singular), .m_clipped(m_clipped)
    );

    // Clock with 20 ns period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    out_t inverses_due[$];
    int   errors = 0;
    int   cycles = 0;
    int   send_idle = 27;
    int   recv_idle = 49;
    bit   hold_armed = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_cnt = 0;

    // Directed rows: the matrix, and the inverse where it is obvious by eye.
    typedef struct {
        mat_t m;
        bit   typed;
        out_t want;
    } row_t;
    row_t rows[$];

    function automatic mat_t mk(elem_t a0, elem_t a1, elem_t a2, elem_t b0, elem_t b1,
                                elem_t b2, elem_t c0, elem_t c1, elem_t c2);
        mat_t m;
        m[0] = a0; m[1] = a1; m[2] = a2;
        m[3] = b0; m[4] = b1; m[5] = b2;
        m[6] = c0; m[7] = c1; m[8] = c2;
        return m;
    endfunction

    function automatic out_t mk_out(mat_t m, bit sing, bit clip);
        out_t o;
        o.res = m;
        o.singular = sing;
        o.clipped = clip;
        return o;
    endfunction

    // Inverse by the adjugate with exact wide arithmetic, rounded half away from zero.
    function automatic out_t inverse_of(mat_t m);
        logic signed [127:0] a[9];
        logic signed [127:0] cof[9];
        logic signed [127:0] det, cv;
        logic [127:0] dmag, num, quo, lim;
        out_t o;
        bit   neg;
        int   r1, r2, c1, c2;
        for (int k = 0; k < 9; k++) a[k] = $signed(m[k]);
        for (int r = 0; r < 3; r++) begin
            r1 = (r + 1) % 3;
            r2 = (r + 2) % 3;
            for (int c = 0; c < 3; c++) begin
                c1 = (c + 1) % 3;
                c2 = (c + 2) % 3;
                cof[r*3+c] = a[r1*3+c1] * a[r2*3+c2] - a[r1*3+c2] * a[r2*3+c1];
            end
        end
        det = a[0] * cof[0] + a[1] * cof[1] + a[2] * cof[2];
        if (det == 0) begin
            return mk_out(m, 1'b1, 1'b0);
        end
        o.singular = 1'b0;
        o.clipped = 1'b0;
        dmag = (det < 0) ? -det : det;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                cv = cof[c*3+r];
                neg = (cv < 0) != (det < 0);
                num = ((cv < 0) ? -cv : cv);
                num = (num << (2 * FRAC + 1)) + dmag;
                quo = num / (dmag << 1);
                lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
                if (quo > lim) begin
                    quo = lim;
                    o.clipped = 1'b1;
                end
                o.res[r*3+c] = neg ? 32'(-quo) : quo[31:0];
            end
        end
        return o;
    endfunction

    function automatic elem_t small_val(int span);
        return elem_t'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic elem_t corner_val();
        case ($urandom_range(6))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hffff_ffff;
            3: return 32'h7fff_ffff;
            4: return 32'h8000_0000;
            5: return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    // Random matrix from several families: dense, well conditioned, singular, sparse, tiny, corners.
    function automatic mat_t random_matrix();
        mat_t m;
        int   k;
        int   f;
        case ($urandom_range(9))
            0, 1, 2: begin
                for (int i = 0; i < 9; i++) m[i] = $urandom;
            end
            3, 4, 5: begin
                for (int i = 0; i < 9; i++) m[i] = small_val(1 << 18);
                for (int i = 0; i < 3; i++) m[i*4] = m[i*4] + 32'h0004_0000;
            end
            6: begin
                // Third row is a multiple of another row, so the determinant is zero.
                for (int i = 0; i < 6; i++) m[i] = small_val(1 << 20);
                k = $urandom_range(1);
                f = int'($urandom_range(6)) - 3;
                for (int c = 0; c < 3; c++) m[6+c] = elem_t'(int'(m[k*3+c]) * f);
            end
            7: begin
                for (int i = 0; i < 9; i++) m[i] = ($urandom_range(3) == 0) ? small_val(1 << 16) : '0;
                for (int i = 0; i < 3; i++) m[i*4] = $urandom;
            end
            8: begin
                for (int i = 0; i < 9; i++) m[i] = corner_val();
            end
            default: begin
                for (int i = 0; i < 9; i++) m[i] = small_val(4);
            end
        endcase
        return m;
    endfunction

    task automatic report(string what, int idx, elem_t got, elem_t want);
        $display("mismatch %s[%0d] at cycle %0d: got %h want %h", what, idx, cycles, got, want);
        errors++;
    endtask

    // Drive one matrix beat and wait until it is taken.
    task automatic send_matrix(mat_t m);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_m00 <= m[0]; s_m01 <= m[1]; s_m02 <= m[2];
        s_m10 <= m[3]; s_m11 <= m[4]; s_m12 <= m[5];
        s_m20 <= m[6]; s_m21 <= m[7]; s_m22 <= m[8];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Cycle count and timeout.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side readiness, with one long hold-off once armed.
    always @(posedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= HOLD_LEN;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Compare every result beat with the oldest expected inverse.
    always @(posedge aclk) begin
        out_t want;
        mat_t got;
        if (aresetn && m_valid && m_ready) begin
            got = mk(m_r00, m_r01, m_r02, m_r10, m_r11, m_r12, m_r20, m_r21, m_r22);
            if (inverses_due.size() == 0) begin
                $display("unexpected result beat at cycle %0d", cycles);
                errors++;
            end else begin
                want = inverses_due.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got[k] !== want.res[k]) report("r", k, got[k], want.res[k]);
                if (m_singular !== want.singular)
                    report("singular", 0, elem_t'(m_singular), elem_t'(want.singular));
                if (m_clipped !== want.clipped)
                    report("clipped", 0, elem_t'(m_clipped), elem_t'(want.clipped));
            end
        end
    end

    initial begin
        mat_t m;
        int   wait_cnt;
        elem_t one_q, mx, mn;
        row_t rw;
        one_q = 32'h0001_0000;
        mx = 32'h7fff_ffff;
        mn = 32'h8000_0000;

        // Identity inverts to itself; doubled identity halves.
        rw.m = mk(one_q, 0, 0, 0, one_q, 0, 0, 0, one_q);
        rw.typed = 1; rw.want = mk_out(rw.m, 0, 0); rows.push_back(rw);
        rw.m = mk(32'h2_0000, 0, 0, 0, 32'h2_0000, 0, 0, 0, 32'h2_0000);
        rw.typed = 1; rw.want = mk_out(mk(32'h8000, 0, 0, 0, 32'h8000, 0, 0, 0, 32'h8000), 0, 0);
        rows.push_back(rw);
        // Singular inputs are echoed unchanged.
        rw.m = '0; rw.typed = 1; rw.want = mk_out(rw.m, 1, 0); rows.push_back(rw);
        rw.m = mk(mx, mx, mx, mx, mx, mx, mx, mx, mx); rw.want = mk_out(rw.m, 1, 0);
        rows.push_back(rw);
        rw.m = mk(mn, mn, mn, mn, mn, mn, mn, mn, mn); rw.want = mk_out(rw.m, 1, 0);
        rows.push_back(rw);
        rw.m = mk(mx, 5, mn, mx, 5, mn, 7, 9, 11); rw.want = mk_out(rw.m, 1, 0);
        rows.push_back(rw);
        // Smallest diagonal: the inverse overflows and saturates in both directions.
        rw.m = mk(1, 0, 0, 0, 1, 0, 0, 0, 1);
        rw.want = mk_out(mk(mx, 0, 0, 0, mx, 0, 0, 0, mx), 0, 1); rows.push_back(rw);
        rw.m = mk(32'hffff_ffff, 0, 0, 0, 1, 0, 0, 0, 1);
        rw.want = mk_out(mk(mn, 0, 0, 0, mx, 0, 0, 0, mx), 0, 1); rows.push_back(rw);
        // Remaining rows go through the model.
        rw.typed = 0;
        rw.m = mk(mx, 0, 0, 0, mx, 0, 0, 0, mx); rows.push_back(rw);
        rw.m = mk(mn, 0, 0, 0, mn, 0, 0, 0, mn); rows.push_back(rw);
        rw.m = mk(0, one_q, 0, 0, 0, one_q, one_q, 0, 0); rows.push_back(rw);
        rw.m = mk(32'h3_0000, 32'hfffe_0000, 32'h0_8000, 0, 32'h1_4000, 32'hffff_0000,
                  0, 0, 32'hfffc_0000); rows.push_back(rw);
        rw.m = mk(one_q, one_q, one_q, one_q, 32'h1_0001, one_q, one_q, one_q, 32'h1_0002);
        rows.push_back(rw);
        rw.m = mk(mx, mn, mx, mn, mx, 1, 32'h5555_5555, 32'haaaa_aaaa, 3); rows.push_back(rw);
        rw.m = mk(32'h0000_b505, 32'hffff_4afb, 0, 32'h0000_b505, 32'h0000_b505, 0,
                  0, 0, one_q); rows.push_back(rw);
        rw.m = mk(mn, mx, 0, 0, mn, mx, mx, 0, mn); rows.push_back(rw);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            inverses_due.push_back(rows[i].typed ? rows[i].want : inverse_of(rows[i].m));
            send_matrix(rows[i].m);
        end

        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == RAND_ITEMS / 3) begin
                send_idle = 49;
                recv_idle = 27;
            end else if (i == 2 * RAND_ITEMS / 3) begin
                send_idle = 0;
                recv_idle = 0;
                hold_armed = 1'b1;
            end
            m = random_matrix();
            inverses_due.push_back(inverse_of(m));
            send_matrix(m);
        end
        s_valid <= 1'b0;

        // Drain, then keep watching for stray beats.
        wait_cnt = 0;
        while (inverses_due.size() != 0 && wait_cnt < 50000) begin
            @(posedge aclk);
            wait_cnt++;
        end
        repeat (TOTAL_LAT + 20) @(posedge aclk);
        if (inverses_due.size() != 0) begin
            $display("%0d expected results never arrived", inverses_due.size());
            errors++;
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
